[hdl/dhkt_pkg.sv]
// Shared constants, codes and types of the double hash key table.
package dhkt_pkg;
	localparam int TABLE_SIZE = 1031;
	localparam int KEY_BYTES = 8;
	localparam int SLOT_AW = $clog2(TABLE_SIZE);
	localparam int BYTE_IW = $clog2(KEY_BYTES);
	localparam int STEP_MOD = 17;
	localparam int STEP_W = $clog2(STEP_MOD + 1);

	typedef logic [SLOT_AW-1:0] slot_addr_t;

	typedef enum logic [1:0] {
		SLOT_EMPTY = 2'd0,
		SLOT_USED  = 2'd1,
		SLOT_TOMB  = 2'd2
	} slot_code_t;

	typedef enum logic [1:0] {
		FUNC_DEFINE = 2'd0,
		FUNC_SET    = 2'd1,
		FUNC_LOOKUP = 2'd2,
		FUNC_DELETE = 2'd3
	} func_code_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_PRESENT   = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_code_t;

	typedef struct packed {
		logic [1:0]  state;
		logic [63:0] key;
		logic [3:0]  key_length;
		logic [31:0] value;
	} slot_entry_t;

	localparam int ENTRY_W = $bits(slot_entry_t);

	typedef struct packed {
		slot_addr_t home;
		slot_addr_t step;
	} hash_res_t;
endpackage

[hdl/dhkt_if.sv]
// Request and response channel interfaces.
interface dhkt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [63:0] key_bytes;
	logic [3:0]  key_length;
	logic [31:0] value_in;
	modport source(output valid, func, key_bytes, key_length, value_in, input ready);
	modport sink(input valid, func, key_bytes, key_length, value_in, output ready);
endinterface

interface dhkt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] value_out;
	modport source(output valid, status, value_out, input ready);
	modport sink(input valid, status, value_out, output ready);
endinterface

[hdl/dhkt_ram.sv]
// Generic simple dual-port RAM with registered read.
module dhkt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[hdl/dhkt_hash.sv]
// Byte-serial double hash with reciprocal-multiply reduction to home slot and step.
module dhkt_hash (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [dhkt_pkg::KEY_BYTES-1:0][7:0]   key,
	input  logic [3:0]                            key_length,
	output logic                                  done,
	output dhkt_pkg::hash_res_t                   res
);
	import dhkt_pkg::*;

	// divisors sit in (2^(W-1), 2^W), so each reciprocal fits 32 bits and the quotient
	// estimate is never more than one low
	localparam int HOME_SH = 31 + SLOT_AW;
	localparam int STEP_SH = 31 + STEP_W;
	localparam logic [31:0] HOME_RECIP = 32'((64'd1 << HOME_SH) / 64'(TABLE_SIZE));
	localparam logic [31:0] STEP_RECIP = 32'((64'd1 << STEP_SH) / 64'(STEP_MOD));

	typedef enum logic [4:0] {
		H_IDLE = 5'b00001,
		H_BYTE = 5'b00010,
		H_MUL  = 5'b00100,
		H_SUB  = 5'b01000,
		H_FIX  = 5'b10000
	} hstate_t;

	hstate_t                      state_q;
	logic [KEY_BYTES-1:0][7:0]    key_q;
	logic [3:0]                   len_q;
	logic [3:0]                   cnt_q;
	logic [31:0]                  h1_q, h2_q;
	logic [63:0]                  p1_q, p2_q;
	logic [SLOT_AW:0]             t1_q;
	logic [STEP_W:0]              t2_q;
	logic                         done_q;
	hash_res_t                    res_q;

	logic [31:0]         c, h1_sum, h2_sum, d1, d2;
	logic [SLOT_AW:0]    f1;
	logic [STEP_W:0]     f2;
	logic [STEP_W-1:0]   step_c;

	always_comb begin
		c = {24'd0, key_q[cnt_q[BYTE_IW-1:0]]};
		h1_sum = h1_q + c + (c << 17);
		h2_sum = h2_q + c + (c << 13);
		// remainder from the quotient estimate, below twice the divisor
		d1 = h1_q - 32'(p1_q[63:HOME_SH]) * 32'(TABLE_SIZE);
		d2 = h2_q - 32'(p2_q[63:STEP_SH]) * 32'(STEP_MOD);
		f1 = t1_q;
		if (t1_q >= (SLOT_AW+1)'(TABLE_SIZE))
			f1 = t1_q - (SLOT_AW+1)'(TABLE_SIZE);
		f2 = t2_q;
		if (t2_q >= (STEP_W+1)'(STEP_MOD))
			f2 = t2_q - (STEP_W+1)'(STEP_MOD);
		step_c = STEP_W'(STEP_MOD) - f2[STEP_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				H_IDLE: begin
					if (start)
						state_q <= H_BYTE;
				end
				H_BYTE: begin
					if (cnt_q == len_q)
						state_q <= H_MUL;
				end
				H_MUL: state_q <= H_SUB;
				H_SUB: state_q <= H_FIX;
				H_FIX: begin
					state_q <= H_IDLE;
					done_q <= 1'b1;
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			H_IDLE: begin
				key_q <= key;
				len_q <= key_length;
				cnt_q <= '0;
				h1_q <= '0;
				h2_q <= '0;
			end
			H_BYTE: begin
				if (cnt_q != len_q) begin
					cnt_q <= cnt_q + 4'd1;
					h1_q <= h1_sum ^ (h1_sum >> 2);
					h2_q <= h2_sum ^ (h2_sum >> 3);
				end
			end
			H_MUL: begin
				p1_q <= 64'(h1_q) * 64'(HOME_RECIP);
				p2_q <= 64'(h2_q) * 64'(STEP_RECIP);
			end
			H_SUB: begin
				t1_q <= d1[SLOT_AW:0];
				t2_q <= d2[STEP_W:0];
			end
			H_FIX: begin
				res_q.home <= f1[SLOT_AW-1:0];
				res_q.step <= SLOT_AW'(step_c);
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign res = res_q;
endmodule

[hdl/double_hash_key_table.sv]
// Open-addressing key/value table, 1031 slots, double hashing with tombstones, one
// response word per request word. After reset a clearing pass writes every slot empty
// before the first request is taken. A request is then hashed one key byte per cycle,
// followed by a reciprocal-multiply reduction (multiply, subtract, fix); each probed
// slot is read from the registered slot memory and then checked, and the result is
// registered into the response. A new request is taken only once the table is idle.
module double_hash_key_table (
	input  logic       clk,
	input  logic       arst_n,
	dhkt_req_if.sink   req,
	dhkt_rsp_if.source rsp
);
	import dhkt_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_HASH  = 6'b000100,
		S_READ  = 6'b001000,
		S_CHECK = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t                     state_q;
	slot_addr_t                 clr_q;
	logic [1:0]                 func_q;
	logic [KEY_BYTES-1:0][7:0]  key_q;
	logic [3:0]                 len_q;
	logic [31:0]                value_q;
	slot_addr_t                 first_q, s_q, step_q;
	logic [1:0]                 res_status_q;
	logic [31:0]                res_value_q;
	logic                       rsp_valid_q;
	logic [1:0]                 status_q;
	logic [31:0]                vout_q;

	logic [3:0]                 len_c;
	logic [KEY_BYTES-1:0][7:0]  key_c;
	logic                       hash_done;
	hash_res_t                  hres;
	logic                       we;
	slot_addr_t                 waddr;
	slot_entry_t                wentry, rentry;
	logic [ENTRY_W-1:0]         rdata;
	logic [SLOT_AW:0]           sum;
	slot_addr_t                 s_next;
	logic                       used, occupied, match, accept;

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);

	always_comb begin
		len_c = (req.key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : req.key_length;
		for (int i = 0; i < KEY_BYTES; i++)
			key_c[i] = (4'(i) < len_c) ? req.key_bytes[8*i +: 8] : 8'd0;
	end

	dhkt_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.key       (key_c),
		.key_length(len_c),
		.done      (hash_done),
		.res       (hres)
	);

	dhkt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wentry),
		.raddr(s_q),
		.rdata(rdata)
	);

	always_comb begin
		rentry = slot_entry_t'(rdata);
		used = (rentry.state == SLOT_USED);
		occupied = used || (rentry.state == SLOT_TOMB);
		match = used && (rentry.key_length == len_q) && (rentry.key == key_q);
		sum = {1'b0, s_q} + {1'b0, step_q};
		if (sum >= (SLOT_AW+1)'(TABLE_SIZE))
			sum = sum - (SLOT_AW+1)'(TABLE_SIZE);
		s_next = sum[SLOT_AW-1:0];

		we = 1'b0;
		waddr = s_q;
		wentry = rentry;
		if (state_q == S_CLEAR) begin
			we = 1'b1;
			waddr = clr_q;
			wentry = '0;
		end else if (state_q == S_CHECK) begin
			case (func_q)
				FUNC_DEFINE, FUNC_SET: begin
					if (!used) begin
						we = 1'b1;
						wentry.state = SLOT_USED;
						wentry.key = key_q;
						wentry.key_length = len_q;
						wentry.value = value_q;
					end else if (match && func_q == FUNC_SET) begin
						we = 1'b1;
						wentry.value = value_q;
					end
				end
				FUNC_DELETE: begin
					if (match) begin
						we = 1'b1;
						wentry.state = SLOT_TOMB;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && (!rsp_valid_q || rsp.ready))
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_AW'(TABLE_SIZE - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept)
						state_q <= S_HASH;
				end
				S_HASH: begin
					if (hash_done)
						state_q <= S_READ;
				end
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					if (func_q == FUNC_DEFINE || func_q == FUNC_SET) begin
						if (!used || match || s_next == first_q)
							state_q <= S_FIN;
						else
							state_q <= S_READ;
					end else begin
						if (!occupied || match || s_next == first_q)
							state_q <= S_FIN;
						else
							state_q <= S_READ;
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.func;
			key_q <= key_c;
			len_q <= len_c;
			value_q <= req.value_in;
		end
		if (state_q == S_HASH && hash_done) begin
			first_q <= hres.home;
			s_q <= hres.home;
			step_q <= hres.step;
		end
		if (state_q == S_CHECK) begin
			s_q <= s_next;
			res_value_q <= '0;
			if (func_q == FUNC_DEFINE || func_q == FUNC_SET) begin
				if (match)
					res_status_q <= (func_q == FUNC_DEFINE) ? ST_PRESENT : ST_OK;
				else if (!used)
					res_status_q <= ST_OK;
				else
					res_status_q <= ST_FULL;
			end else begin
				if (match) begin
					res_status_q <= ST_OK;
					if (func_q == FUNC_LOOKUP)
						res_value_q <= rentry.value;
				end else begin
					res_status_q <= ST_NOT_FOUND;
				end
			end
		end
		if (state_q == S_FIN && (!rsp_valid_q || rsp.ready)) begin
			status_q <= res_status_q;
			vout_q <= res_value_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = status_q;
	assign rsp.value_out = vout_q;

`ifndef ASSERT_OFF
	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_CLEAR || state_q == S_CHECK))
		else $error("slot write outside clear or probe check");
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> (32'(s_q) < TABLE_SIZE && 32'(step_q) < TABLE_SIZE))
		else $error("probe address out of range");
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |-> (rsp.value_out == 32'd0))
		else $error("nonzero value on failed request");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_HASH))
		else $error("accepted word did not start hashing");
`endif
endmodule
